// File: src/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg: shared types and constants of the modular exponentiation unit
// State encodings, register indexes and register reset values.
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 2'd1;

  localparam logic [31:0] EXPONENT_RESET = 32'd7;
  localparam logic [31:0] MODULUS_RESET  = 32'd3233;

  typedef enum logic [2:0] {
    TOP_IDLE,
    TOP_RED,
    TOP_NEXT,
    TOP_MULT,
    TOP_SQR,
    TOP_DONE
  } top_state_e;

  typedef enum logic [1:0] {
    MUL_IDLE,
    MUL_DBL,
    MUL_ADD
  } mul_state_e;

endpackage

// File: src/mexp_mulmod.sv
// ----------------------------------------------------------------------------
// mexp_mulmod: bit-serial modular multiplier
// Forms a * b mod m by scanning b from its top bit: double the partial
// result, then add a when the bit is set, reducing after every addition.
// ----------------------------------------------------------------------------
module mexp_mulmod #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [OPERAND_WIDTH-1:0] a_i,
  input  logic [OPERAND_WIDTH-1:0] b_i,
  input  logic [OPERAND_WIDTH-1:0] m_i,
  output logic                     done_o,
  output logic [OPERAND_WIDTH-1:0] res_o
);

  localparam int unsigned CntW = $clog2(OPERAND_WIDTH + 1);

  mexp_pkg::mul_state_e state_q, state_d;
  logic                     done_q, done_d;
  logic [OPERAND_WIDTH-1:0] acc_q, acc_d;
  logic [OPERAND_WIDTH-1:0] a_q, a_d;
  logic [OPERAND_WIDTH-1:0] b_q, b_d;
  logic [OPERAND_WIDTH-1:0] m_q, m_d;
  logic [CntW-1:0]          cnt_q, cnt_d;

  logic [OPERAND_WIDTH-1:0] operand;
  logic [OPERAND_WIDTH:0]   sum;
  logic [OPERAND_WIDTH+1:0] diff;
  logic [OPERAND_WIDTH-1:0] step_res;
  logic                     bit_end;

  assign operand  = (state_q == mexp_pkg::MUL_DBL) ? acc_q : a_q;
  assign sum      = {1'b0, acc_q} + {1'b0, operand};
  assign diff     = {1'b0, sum} - {2'b00, m_q};
  assign step_res = diff[OPERAND_WIDTH+1] ? sum[OPERAND_WIDTH-1:0]
                                          : diff[OPERAND_WIDTH-1:0];

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    acc_d   = acc_q;
    a_d     = a_q;
    b_d     = b_q;
    m_d     = m_q;
    cnt_d   = cnt_q;
    bit_end = 1'b0;
    case (state_q)
      mexp_pkg::MUL_IDLE: begin
        if (start_i) begin
          a_d     = a_i;
          b_d     = b_i;
          m_d     = m_i;
          acc_d   = '0;
          cnt_d   = CntW'(OPERAND_WIDTH);
          state_d = mexp_pkg::MUL_DBL;
        end
      end
      mexp_pkg::MUL_DBL: begin
        acc_d = step_res;
        if (b_q[OPERAND_WIDTH-1]) begin
          state_d = mexp_pkg::MUL_ADD;
        end else begin
          bit_end = 1'b1;
        end
      end
      mexp_pkg::MUL_ADD: begin
        acc_d   = step_res;
        bit_end = 1'b1;
        state_d = mexp_pkg::MUL_DBL;
      end
      default: state_d = mexp_pkg::MUL_IDLE;
    endcase
    if (bit_end) begin
      b_d   = {b_q[OPERAND_WIDTH-2:0], 1'b0};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        state_d = mexp_pkg::MUL_IDLE;
        done_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mexp_pkg::MUL_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
    m_q   <= m_d;
    cnt_q <= cnt_d;
  end

  assign done_o = done_q;
  assign res_o  = acc_q;

`ifndef ASSERT_OFF
  a_acc_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != mexp_pkg::MUL_IDLE) |-> (acc_q < m_q))
    else $error("partial product not below modulus");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == mexp_pkg::MUL_IDLE))
    else $error("multiplier done while still working");

  a_done_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_q) |-> ($past(state_q) != mexp_pkg::MUL_IDLE))
    else $error("multiplier done without a multiplication");
`endif

endmodule

// File: src/modular_exponentiation_unit.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_unit: base ^ exponent mod modulus
// Right-to-left square and multiply over one bit-serial modular multiplier.
// ----------------------------------------------------------------------------
// Write the exponent (index 0) and modulus (index 1) through cfg_we_i,
// cfg_idx_i and cfg_data_i while no request is in flight; other indexes
// are ignored. Reset loads exponent 7 and modulus 3233 and empties the unit.
// A request on base_value_i is taken when in_valid_i and in_ready_o are
// high; one result comes out on power_result_o under out_valid_o and
// out_ready_i. One request is worked on at a time.
// Each modular multiplication runs one doubling step per multiplier bit
// and one addition step per set bit in the shared multiplier. A request
// runs one reduction of the base, then per exponent bit up to its highest
// set bit one squaring and, for a set bit, one multiplication. Exponent
// zero or modulus zero skip the multiplier.
// A finished result waits in the output register while the receiver
// stalls; the next request is taken meanwhile and holds at its end until
// the output register is free.
// ----------------------------------------------------------------------------
module modular_exponentiation_unit #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [mexp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [OPERAND_WIDTH-1:0]           cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [OPERAND_WIDTH-1:0]           base_value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [OPERAND_WIDTH-1:0]           power_result_o
);

  localparam logic [OPERAND_WIDTH-1:0] One = OPERAND_WIDTH'(1);

  mexp_pkg::top_state_e state_q, state_d;
  logic [OPERAND_WIDTH-1:0] exp_q, exp_d;
  logic [OPERAND_WIDTH-1:0] mod_q, mod_d;
  logic [OPERAND_WIDTH-1:0] e_q, e_d;
  logic [OPERAND_WIDTH-1:0] m_q, m_d;
  logic [OPERAND_WIDTH-1:0] base_q, base_d;
  logic [OPERAND_WIDTH-1:0] acc_q, acc_d;
  logic                     out_valid_q, out_valid_d;
  logic [OPERAND_WIDTH-1:0] result_q, result_d;

  logic                     in_accept;
  logic [OPERAND_WIDTH-1:0] one_mod;
  logic                     mul_start;
  logic [OPERAND_WIDTH-1:0] mul_a, mul_b, mul_m;
  logic                     mul_done;
  logic [OPERAND_WIDTH-1:0] mul_res;

  assign in_ready_o = (state_q == mexp_pkg::TOP_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  assign one_mod    = (mod_q == One) ? '0 : One;

  always_comb begin
    exp_d = exp_q;
    mod_d = mod_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        mexp_pkg::REG_EXPONENT: exp_d = cfg_data_i;
        mexp_pkg::REG_MODULUS:  mod_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    e_d         = e_q;
    m_d         = m_q;
    base_d      = base_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q && !out_ready_i;
    result_d    = result_q;
    mul_start   = 1'b0;
    mul_a       = base_q;
    mul_b       = base_q;
    mul_m       = m_q;
    case (state_q)
      mexp_pkg::TOP_IDLE: begin
        if (in_accept) begin
          e_d = exp_q;
          m_d = mod_q;
          if (exp_q == '0) begin
            acc_d   = One;
            state_d = mexp_pkg::TOP_DONE;
          end else if (mod_q == '0) begin
            acc_d   = '0;
            state_d = mexp_pkg::TOP_DONE;
          end else begin
            acc_d     = one_mod;
            mul_start = 1'b1;
            mul_a     = one_mod;
            mul_b     = base_value_i;
            mul_m     = mod_q;
            state_d   = mexp_pkg::TOP_RED;
          end
        end
      end
      mexp_pkg::TOP_RED: begin
        if (mul_done) begin
          base_d  = mul_res;
          state_d = mexp_pkg::TOP_NEXT;
        end
      end
      mexp_pkg::TOP_NEXT: begin
        mul_start = 1'b1;
        if (e_q[0]) begin
          mul_a   = acc_q;
          state_d = mexp_pkg::TOP_MULT;
        end else begin
          state_d = mexp_pkg::TOP_SQR;
        end
      end
      mexp_pkg::TOP_MULT: begin
        if (mul_done) begin
          acc_d     = mul_res;
          mul_start = 1'b1;
          state_d   = mexp_pkg::TOP_SQR;
        end
      end
      mexp_pkg::TOP_SQR: begin
        if (mul_done) begin
          base_d = mul_res;
          e_d    = {1'b0, e_q[OPERAND_WIDTH-1:1]};
          if (e_q[OPERAND_WIDTH-1:1] == '0) begin
            state_d = mexp_pkg::TOP_DONE;
          end else begin
            state_d = mexp_pkg::TOP_NEXT;
          end
        end
      end
      mexp_pkg::TOP_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          result_d    = acc_q;
          state_d     = mexp_pkg::TOP_IDLE;
        end
      end
      default: state_d = mexp_pkg::TOP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mexp_pkg::TOP_IDLE;
      out_valid_q <= 1'b0;
      exp_q       <= OPERAND_WIDTH'(mexp_pkg::EXPONENT_RESET);
      mod_q       <= OPERAND_WIDTH'(mexp_pkg::MODULUS_RESET);
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      exp_q       <= exp_d;
      mod_q       <= mod_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e_q      <= e_d;
    m_q      <= m_d;
    base_q   <= base_d;
    acc_q    <= acc_d;
    result_q <= result_d;
  end

  mexp_mulmod #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_mulmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .m_i    (mul_m),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  assign out_valid_o    = out_valid_q;
  assign power_result_o = result_q;

`ifndef ASSERT_OFF
  a_done_in_mul_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == mexp_pkg::TOP_RED || state_q == mexp_pkg::TOP_MULT ||
                  state_q == mexp_pkg::TOP_SQR))
    else $error("multiplier result with no multiplication pending");

  a_exp_zero_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && exp_q == '0) |=> (state_q == mexp_pkg::TOP_DONE && acc_q == One))
    else $error("zero exponent does not give one");

  a_next_has_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mexp_pkg::TOP_NEXT) |-> (e_q != '0))
    else $error("exponent step with no bits left");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == mexp_pkg::TOP_DONE))
    else $error("result posted outside the final state");
`endif

endmodule
